@@ hw/rtl/bth_pkg.sv @@
// Shared constants, codes and types of the boundary-tag heap allocator.
package bth_pkg;

	localparam int DEF_ARENA_BYTES = 64 * 1024;
	localparam int DEF_MIN_PAYLOAD = 16;
	localparam int ALIGN_BYTES     = 8;
	localparam int HDR_BYTES       = 8;
	localparam int DEF_WORDS       = DEF_ARENA_BYTES / 8;

	// Byte offsets carry two spare bits so that offset plus size never wraps.
	localparam int OFF_W  = 18;
	localparam int DATA_W = 64;

	// Request operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FAIL   = 2'd1,
		ST_ZERO   = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	// One access slot of the arena memory: one write and one read a cycle.
	typedef struct packed {
		logic              wr_en;
		logic [OFF_W-1:0]  wr_off;
		logic [DATA_W-1:0] wr_data;
		logic [OFF_W-1:0]  rd_off;
	} bth_mem_req_t;

endpackage

@@ hw/rtl/bth_arena.sv @@
// Arena word memory addressed by byte offset, with a registered read port.
module bth_arena import bth_pkg::*; #(
	parameter int WORDS = DEF_WORDS
) (
	input  logic              clk,
	input  bth_mem_req_t      req,
	output logic [DATA_W-1:0] rd_data
);

	localparam int IDX_W = $clog2(WORDS);

	logic [DATA_W-1:0] mem [WORDS];
	logic [DATA_W-1:0] raw_q;
	logic              rd_in_q;
	logic              wr_in;
	logic              rd_in;

	// Offsets past the arena read as zero and ignore writes.
	assign wr_in = req.wr_off[OFF_W-1:3] < (OFF_W-3)'(WORDS);
	assign rd_in = req.rd_off[OFF_W-1:3] < (OFF_W-3)'(WORDS);

	always_ff @(posedge clk) begin
		if (req.wr_en && wr_in) begin
			mem[req.wr_off[IDX_W+2:3]] <= req.wr_data;
		end
		raw_q   <= mem[req.rd_off[IDX_W+2:3]];
		rd_in_q <= rd_in;
	end

	assign rd_data = rd_in_q ? raw_q : '0;

endmodule

@@ hw/rtl/boundary_tag_heap_allocator.sv @@
// Top level of the boundary-tag first-fit heap allocator.
// After reset the block sweeps the arena memory once, one word a cycle
// (ARENA_BYTES/8 words, 8192 at the default size), before it takes a request.
// Each request then runs on a small sequencer around the single arena memory
// port: at most one header or link word is read and one written per cycle. An
// allocate takes the request, examines free-list entries one by one, updates
// headers and list links and posts the result; a free walks the blocks from
// the arena start to the freed block, then merges neighbors and updates the list.
// The block takes one request at a time; a finished result waits in the
// output register until it is taken.
module boundary_tag_heap_allocator import bth_pkg::*; #(
	parameter int ARENA_BYTES = DEF_ARENA_BYTES,
	parameter int MIN_PAYLOAD = DEF_MIN_PAYLOAD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [15:0] request_size,
	input  logic [15:0] address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] payload_offset,
	output logic [1:0]  status,
	output logic [11:0] free_blocks
);

	localparam int WORDS = ARENA_BYTES / 8;
	localparam int IDX_W = $clog2(WORDS);
	localparam int NS    = 38;
	localparam logic [15:0] FIRST_SZ = 16'(ARENA_BYTES - 2 * HDR_BYTES);
	localparam logic [DATA_W-1:0] FIRST_HDR = {15'd0, 1'b0, 16'd0, 15'd0, 1'b1, FIRST_SZ};
	localparam logic [DATA_W-1:0] SENT_HDR  = {15'd0, 1'b1, FIRST_SZ, 15'd0, 1'b0, 16'd0};
	localparam logic [OFF_W-1:0] HDR_O   = OFF_W'(HDR_BYTES);
	localparam logic [OFF_W-1:0] WALK_END = OFF_W'(ARENA_BYTES - HDR_BYTES);
	localparam logic [OFF_W-1:0] SPLIT_EXTRA = OFF_W'(HDR_BYTES + MIN_PAYLOAD);

	typedef enum logic [NS-1:0] {
		S_INIT      = NS'(1) << 0,
		S_IDLE      = NS'(1) << 1,
		S_A_HDR_RD  = NS'(1) << 2,
		S_A_HDR     = NS'(1) << 3,
		S_A_LNK     = NS'(1) << 4,
		S_SP_NB     = NS'(1) << 5,
		S_SP_AFT_RD = NS'(1) << 6,
		S_SP_AFT_WR = NS'(1) << 7,
		S_A_FIN     = NS'(1) << 8,
		S_A_TK_RD   = NS'(1) << 9,
		S_A_TK_WR   = NS'(1) << 10,
		S_A_AFT_RD  = NS'(1) << 11,
		S_A_AFT_WR  = NS'(1) << 12,
		S_IN_RD     = NS'(1) << 13,
		S_IN_WR     = NS'(1) << 14,
		S_IN_LNK    = NS'(1) << 15,
		S_D_RD      = NS'(1) << 16,
		S_D_LNK     = NS'(1) << 17,
		S_D_N_WR    = NS'(1) << 18,
		S_D_P_RD    = NS'(1) << 19,
		S_D_P_WR    = NS'(1) << 20,
		S_D_END     = NS'(1) << 21,
		S_F_WALK    = NS'(1) << 22,
		S_F_STEP    = NS'(1) << 23,
		S_F_B_WR    = NS'(1) << 24,
		S_F_AFT_RD  = NS'(1) << 25,
		S_F_AFT_WR  = NS'(1) << 26,
		S_F_BEF_RD  = NS'(1) << 27,
		S_F_BEF_WR  = NS'(1) << 28,
		S_F_AFT2_RD = NS'(1) << 29,
		S_F_AFT2_WR = NS'(1) << 30,
		S_F_RIGHT   = NS'(1) << 31,
		S_F_B2_RD   = NS'(1) << 32,
		S_F_B2_WR   = NS'(1) << 33,
		S_F_FAR_RD  = NS'(1) << 34,
		S_F_FAR_WR  = NS'(1) << 35,
		S_F_INS     = NS'(1) << 36,
		S_DONE      = NS'(1) << 37
	} state_t;

	state_t            state_q, ret_q;
	logic [IDX_W-1:0]  init_idx_q;
	logic [15:0]       free_head_q;
	logic [11:0]       free_count_q;
	logic [11:0]       k_q;
	logic [16:0]       s_q;
	logic [OFF_W-1:0]  cur_q, taken_q, b_q, aft_q, tgt_q;
	logic [15:0]       rest_q, bsz_q, blsz_q, aftsz_q, newsz_q;
	logic              blf_q, aftfree_q;
	logic [15:0]       n_q, p_q;
	logic              nv_q, pv_q;
	logic [15:0]       pay_q;
	status_t           st_q;
	logic              out_valid_q;
	logic [15:0]       payload_offset_q;
	logic [1:0]        status_q;
	logic [11:0]       free_blocks_q;

	bth_mem_req_t      mreq;
	logic [DATA_W-1:0] rd;
	logic [16:0]       req17, smax, s_new;
	logic [15:0]       sz, rest, lsum, rsum;
	logic              out_load;
	state_t            ins_entry;

	bth_arena #(.WORDS(WORDS)) u_arena (
		.clk     (clk),
		.req     (mreq),
		.rd_data (rd)
	);

	// Request size raised to the minimum payload and rounded to the alignment.
	assign req17 = {1'b0, request_size};
	assign smax  = (req17 > 17'(MIN_PAYLOAD)) ? req17 : 17'(MIN_PAYLOAD);
	assign s_new = (smax + 17'(ALIGN_BYTES - 1)) & ~17'(ALIGN_BYTES - 1);

	assign sz   = rd[15:0];
	assign rest = sz - 16'(HDR_BYTES) - s_q[15:0];
	assign lsum = rd[15:0] + bsz_q + 16'(HDR_BYTES);
	assign rsum = rd[15:0] + aftsz_q + 16'(HDR_BYTES);

	// A push onto an empty list skips relinking the old head.
	assign ins_entry = (free_count_q != 12'd0) ? S_IN_RD : S_IN_LNK;

	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Memory address and write data for each sequencer step.
	always_comb begin
		mreq = '0;
		case (state_q)
			S_INIT: begin
				mreq.wr_en  = 1'b1;
				mreq.wr_off = OFF_W'({init_idx_q, 3'b000});
				if (init_idx_q == '0) begin
					mreq.wr_data = FIRST_HDR;
				end else if (init_idx_q == IDX_W'(WORDS - 1)) begin
					mreq.wr_data = SENT_HDR;
				end
			end
			S_A_HDR_RD: mreq.rd_off = cur_q;
			S_A_HDR: begin
				mreq.rd_off = cur_q + HDR_O;
				if (({1'b0, sz} != s_q) &&
				    ({2'b0, sz} >= ({1'b0, s_q} + SPLIT_EXTRA))) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_off  = cur_q;
					mreq.wr_data = {rd[63:16], rest};
				end
			end
			S_SP_NB: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = cur_q + HDR_O + OFF_W'(rest_q);
				mreq.wr_data = {15'd0, 1'b1, rest_q, 15'd0, 1'b1, s_q[15:0]};
			end
			S_SP_AFT_RD: mreq.rd_off = aft_q;
			S_SP_AFT_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = aft_q;
				mreq.wr_data = {rd[63:49], 1'b1, s_q[15:0], rd[31:0]};
			end
			S_A_TK_RD: mreq.rd_off = taken_q;
			S_A_TK_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = taken_q;
				mreq.wr_data = {rd[63:17], 1'b0, rd[15:0]};
			end
			S_A_AFT_RD: mreq.rd_off = aft_q;
			S_A_AFT_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = aft_q;
				mreq.wr_data = {rd[63:49], 1'b0, rd[47:0]};
			end
			S_IN_RD: mreq.rd_off = OFF_W'(free_head_q) + HDR_O;
			S_IN_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = OFF_W'(free_head_q) + HDR_O;
				mreq.wr_data = {rd[63:49], 1'b1, tgt_q[15:0], rd[31:0]};
			end
			S_IN_LNK: begin
				mreq.wr_en  = 1'b1;
				mreq.wr_off = tgt_q + HDR_O;
				if (free_count_q != 12'd0) begin
					mreq.wr_data = {47'd0, 1'b1, free_head_q};
				end
			end
			S_D_RD:  mreq.rd_off = tgt_q + HDR_O;
			S_D_LNK: mreq.rd_off = OFF_W'(rd[15:0]) + HDR_O;
			S_D_N_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = OFF_W'(n_q) + HDR_O;
				mreq.wr_data = {rd[63:49], pv_q, p_q, rd[31:0]};
			end
			S_D_P_RD: mreq.rd_off = OFF_W'(p_q) + HDR_O;
			S_D_P_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = OFF_W'(p_q) + HDR_O;
				mreq.wr_data = {rd[63:17], nv_q, n_q};
			end
			S_F_WALK: mreq.rd_off = cur_q;
			S_F_B_WR: begin
				mreq.wr_en   = !rd[16];
				mreq.wr_off  = b_q;
				mreq.wr_data = {rd[63:17], 1'b1, rd[15:0]};
			end
			S_F_AFT_RD: mreq.rd_off = aft_q;
			S_F_AFT_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = aft_q;
				mreq.wr_data = {rd[63:49], 1'b1, rd[47:0]};
			end
			S_F_BEF_RD: mreq.rd_off = tgt_q;
			S_F_BEF_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = tgt_q;
				mreq.wr_data = {rd[63:16], lsum};
			end
			S_F_AFT2_RD: mreq.rd_off = aft_q;
			S_F_AFT2_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = aft_q;
				mreq.wr_data = {rd[63:48], newsz_q, rd[31:0]};
			end
			S_F_B2_RD: mreq.rd_off = b_q;
			S_F_B2_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = b_q;
				mreq.wr_data = {rd[63:16], rsum};
			end
			S_F_FAR_RD: mreq.rd_off = cur_q;
			S_F_FAR_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_off  = cur_q;
				mreq.wr_data = {rd[63:49], 1'b1, newsz_q, rd[31:0]};
			end
			default: mreq = '0;
		endcase
	end

	// Sequencer control and list state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			ret_q        <= S_DONE;
			init_idx_q   <= '0;
			free_head_q  <= 16'd0;
			free_count_q <= 12'd1;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_idx_q <= init_idx_q + 1'b1;
					if (init_idx_q == IDX_W'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						pay_q <= 16'd0;
						if (op == OP_ALLOC) begin
							s_q   <= s_new;
							cur_q <= OFF_W'(free_head_q);
							k_q   <= 12'd0;
							if (request_size == 16'd0) begin
								st_q    <= ST_ZERO;
								state_q <= S_DONE;
							end else if (free_count_q == 12'd0) begin
								st_q    <= ST_FAIL;
								state_q <= S_DONE;
							end else begin
								state_q <= S_A_HDR_RD;
							end
						end else begin
							b_q   <= OFF_W'(address) - HDR_O;
							cur_q <= '0;
							if (address == 16'd0) begin
								st_q    <= ST_OK;
								state_q <= S_DONE;
							end else if (address[2:0] != 3'd0) begin
								st_q    <= ST_FAIL;
								state_q <= S_DONE;
							end else begin
								state_q <= S_F_WALK;
							end
						end
					end
				end
				// Walk the free list: exact fit, split, or follow the link.
				S_A_HDR_RD: state_q <= S_A_HDR;
				S_A_HDR: begin
					if ({1'b0, sz} == s_q) begin
						taken_q <= cur_q;
						state_q <= S_A_FIN;
					end else if ({2'b0, sz} >= ({1'b0, s_q} + SPLIT_EXTRA)) begin
						rest_q  <= rest;
						state_q <= S_SP_NB;
					end else begin
						state_q <= S_A_LNK;
					end
				end
				S_A_LNK: begin
					cur_q <= OFF_W'(rd[15:0]);
					k_q   <= k_q + 12'd1;
					if (!rd[16] || ((k_q + 12'd1) >= free_count_q)) begin
						st_q    <= ST_FAIL;
						state_q <= S_DONE;
					end else begin
						state_q <= S_A_HDR_RD;
					end
				end
				// Split the tail off the chosen block and push it.
				S_SP_NB: begin
					taken_q <= cur_q + HDR_O + OFF_W'(rest_q);
					aft_q   <= cur_q + HDR_O + OFF_W'(rest_q) + HDR_O + OFF_W'(s_q[15:0]);
					state_q <= S_SP_AFT_RD;
				end
				S_SP_AFT_RD: state_q <= S_SP_AFT_WR;
				S_SP_AFT_WR: begin
					tgt_q   <= taken_q;
					ret_q   <= S_A_FIN;
					state_q <= ins_entry;
				end
				// The last free block is never handed out.
				S_A_FIN: begin
					if ((taken_q == OFF_W'(free_head_q)) && (free_count_q == 12'd1)) begin
						st_q    <= ST_FAIL;
						state_q <= S_DONE;
					end else begin
						tgt_q   <= taken_q;
						ret_q   <= S_A_TK_RD;
						state_q <= S_D_RD;
					end
				end
				S_A_TK_RD: state_q <= S_A_TK_WR;
				S_A_TK_WR: begin
					aft_q   <= taken_q + HDR_O + OFF_W'(rd[15:0]);
					state_q <= S_A_AFT_RD;
				end
				S_A_AFT_RD: state_q <= S_A_AFT_WR;
				S_A_AFT_WR: begin
					pay_q   <= 16'(taken_q + HDR_O);
					st_q    <= ST_OK;
					state_q <= S_DONE;
				end
				// Push the target block at the list head.
				S_IN_RD: state_q <= S_IN_WR;
				S_IN_WR: state_q <= S_IN_LNK;
				S_IN_LNK: begin
					free_head_q  <= tgt_q[15:0];
					free_count_q <= free_count_q + 12'd1;
					state_q      <= ret_q;
				end
				// Unlink the target block from the list.
				S_D_RD: state_q <= S_D_LNK;
				S_D_LNK: begin
					nv_q <= rd[16];
					n_q  <= rd[15:0];
					pv_q <= rd[48];
					p_q  <= rd[47:32];
					if (rd[16]) begin
						state_q <= S_D_N_WR;
					end else if (rd[48]) begin
						state_q <= S_D_P_RD;
					end else begin
						free_head_q <= rd[15:0];
						state_q     <= S_D_END;
					end
				end
				S_D_N_WR: begin
					if (pv_q) begin
						state_q <= S_D_P_RD;
					end else begin
						free_head_q <= n_q;
						state_q     <= S_D_END;
					end
				end
				S_D_P_RD: state_q <= S_D_P_WR;
				S_D_P_WR: state_q <= S_D_END;
				S_D_END: begin
					if (free_count_q != 12'd0) begin
						free_count_q <= free_count_q - 12'd1;
					end
					state_q <= ret_q;
				end
				// Walk the arena by headers to validate the freed address.
				S_F_WALK: begin
					if (cur_q >= WALK_END) begin
						st_q    <= ST_FAIL;
						state_q <= S_DONE;
					end else if (cur_q == b_q) begin
						state_q <= S_F_B_WR;
					end else begin
						state_q <= S_F_STEP;
					end
				end
				S_F_STEP: begin
					cur_q   <= cur_q + HDR_O + OFF_W'(rd[15:0]);
					state_q <= S_F_WALK;
				end
				S_F_B_WR: begin
					bsz_q  <= rd[15:0];
					blsz_q <= rd[47:32];
					blf_q  <= rd[48];
					aft_q  <= b_q + HDR_O + OFF_W'(rd[15:0]);
					if (rd[16]) begin
						st_q    <= ST_DOUBLE;
						state_q <= S_DONE;
					end else begin
						st_q    <= ST_OK;
						state_q <= S_F_AFT_RD;
					end
				end
				S_F_AFT_RD: state_q <= S_F_AFT_WR;
				S_F_AFT_WR: begin
					aftfree_q <= rd[16];
					aftsz_q   <= rd[15:0];
					tgt_q     <= b_q - HDR_O - OFF_W'(blsz_q);
					state_q   <= blf_q ? S_F_BEF_RD : S_F_RIGHT;
				end
				// Merge with the free left neighbor.
				S_F_BEF_RD: state_q <= S_F_BEF_WR;
				S_F_BEF_WR: begin
					newsz_q <= lsum;
					state_q <= S_F_AFT2_RD;
				end
				S_F_AFT2_RD: state_q <= S_F_AFT2_WR;
				S_F_AFT2_WR: begin
					b_q     <= tgt_q;
					ret_q   <= S_F_RIGHT;
					state_q <= S_D_RD;
				end
				// Merge with the free right neighbor, then push.
				S_F_RIGHT: begin
					if (aftfree_q) begin
						state_q <= S_F_B2_RD;
					end else begin
						tgt_q   <= b_q;
						ret_q   <= S_DONE;
						state_q <= ins_entry;
					end
				end
				S_F_B2_RD: state_q <= S_F_B2_WR;
				S_F_B2_WR: begin
					newsz_q <= rsum;
					cur_q   <= aft_q + HDR_O + OFF_W'(aftsz_q);
					state_q <= S_F_FAR_RD;
				end
				S_F_FAR_RD: state_q <= S_F_FAR_WR;
				S_F_FAR_WR: begin
					tgt_q   <= aft_q;
					ret_q   <= S_F_INS;
					state_q <= S_D_RD;
				end
				S_F_INS: begin
					tgt_q   <= b_q;
					ret_q   <= S_DONE;
					state_q <= ins_entry;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			payload_offset_q <= pay_q;
			status_q         <= st_q;
			free_blocks_q    <= free_count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign payload_offset = payload_offset_q;
	assign status         = status_q;
	assign free_blocks    = free_blocks_q;

endmodule

@@ verif/tb_boundary_tag_heap_allocator.sv @@
// Self-checking testbench of the boundary-tag first-fit heap allocator.
`timescale 1ns / 1ps

module tb_boundary_tag_heap_allocator import bth_pkg::*;;

	localparam int          ARENA     = DEF_ARENA_BYTES;
	localparam int          NWORDS    = ARENA / 8;
	localparam int          MINPAY    = DEF_MIN_PAYLOAD;
	localparam int unsigned CYCLE_CAP = 4000000;
	localparam int          LIVE_CAP  = 48;

	typedef struct {
		logic [15:0] pay;
		status_t     st;
		logic [11:0] fb;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = OP_ALLOC;
	logic [15:0] request_size = '0;
	logic [15:0] address = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] payload_offset;
	logic [1:0]  status;
	logic [11:0] free_blocks;

	// Mirror of the arena and of the free-list registers.
	bit [63:0]   heap_img [0:NWORDS-1];
	int unsigned list_head;
	int unsigned list_len;

	alloc_result_t pending_results[$];
	logic [15:0]   live_blocks[$];
	logic [15:0]   released[$];
	int unsigned   cycle_cnt = 0;
	int            mismatches = 0;
	int            hold_len = 0;
	int            hold_cycles = 0;
	bit            hold_started = 1'b0;
	bit            quiet = 1'b0;

	boundary_tag_heap_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .request_size(request_size), .address(address),
		.out_valid(out_valid), .out_ready(out_ready),
		.payload_offset(payload_offset), .status(status), .free_blocks(free_blocks)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Word and field access on the mirrored arena.
	function automatic bit [63:0] hrd(int unsigned off);
		int unsigned i = off >> 3;
		return (i < NWORDS) ? heap_img[i] : 64'd0;
	endfunction

	function automatic void hwr(int unsigned off, bit [63:0] v);
		int unsigned i = off >> 3;
		if (i < NWORDS) heap_img[i] = v;
	endfunction

	function automatic int unsigned fld(int unsigned off, int sh);
		return 32'((hrd(off) >> sh) & 64'hFFFF);
	endfunction

	function automatic bit flag(int unsigned off, int sh);
		bit [63:0] w = hrd(off);
		return w[sh + 16];
	endfunction

	function automatic void set_fld(int unsigned off, int sh, int unsigned v);
		bit [63:0] w = hrd(off) & ~(64'hFFFF << sh);
		hwr(off, w | ((64'(v) & 64'hFFFF) << sh));
	endfunction

	function automatic void set_flag(int unsigned off, int sh, bit b);
		bit [63:0] w = hrd(off);
		w[sh + 16] = b;
		hwr(off, w);
	endfunction

	function automatic int unsigned follower(int unsigned b);
		return b + HDR_BYTES + fld(b, 0);
	endfunction

	function automatic void heap_reset();
		int unsigned first = ARENA - 2 * HDR_BYTES;
		foreach (heap_img[i]) heap_img[i] = '0;
		hwr(0, 64'(first) | (64'd1 << 16));
		hwr(ARENA - HDR_BYTES, (64'(first) << 32) | (64'd1 << 48));
		list_head = 0;
		list_len = 1;
	endfunction

	// Remove a block from the doubly linked free list.
	function automatic void unlink(int unsigned b);
		int unsigned lw = b + HDR_BYTES;
		bit          nv = flag(lw, 0);
		bit          pv = flag(lw, 32);
		int unsigned n = fld(lw, 0);
		int unsigned p = fld(lw, 32);
		if (nv) begin
			set_fld(n + HDR_BYTES, 32, p);
			set_flag(n + HDR_BYTES, 32, pv);
		end
		if (pv) begin
			set_fld(p + HDR_BYTES, 0, n);
			set_flag(p + HDR_BYTES, 0, nv);
		end else begin
			list_head = n;
		end
		if (list_len > 0) list_len--;
	endfunction

	// Push a block onto the head of the free list.
	function automatic void push_free(int unsigned b);
		bit [63:0] lnk = '0;
		if (list_len > 0) begin
			lnk = 64'(list_head & 16'hFFFF) | (64'd1 << 16);
			set_fld(list_head + HDR_BYTES, 32, b);
			set_flag(list_head + HDR_BYTES, 32, 1'b1);
		end
		hwr(b + HDR_BYTES, lnk);
		list_head = b & 16'hFFFF;
		list_len = (list_len + 1) & 12'hFFF;
	endfunction

	// Cut a block of s payload bytes off the tail of free block b.
	function automatic int unsigned carve(int unsigned b, int unsigned s);
		int unsigned rest = fld(b, 0) - (HDR_BYTES + s);
		int unsigned nb, aft;
		set_fld(b, 0, rest);
		nb = follower(b);
		hwr(nb, 64'(s) | (64'd1 << 16) | (64'(rest) << 32) | (64'd1 << 48));
		aft = follower(nb);
		set_fld(aft, 32, s);
		set_flag(aft, 32, 1'b1);
		push_free(nb);
		return nb;
	endfunction

	function automatic status_t predict_alloc(int unsigned req, output logic [15:0] pay);
		int unsigned s, cur, sz, taken = 0;
		bit          found = 0;
		pay = '0;
		if (req == 0) return ST_ZERO;
		s = (req > MINPAY) ? req : MINPAY;
		s = (s + 7) & ~32'd7;
		cur = list_head;
		for (int unsigned k = 0; k < list_len && k < NWORDS; k++) begin
			sz = fld(cur, 0);
			if (sz == s) begin
				taken = cur; found = 1; break;
			end
			if (sz >= s + HDR_BYTES + MINPAY) begin
				taken = carve(cur, s); found = 1; break;
			end
			if (!flag(cur + HDR_BYTES, 0)) break;
			cur = fld(cur + HDR_BYTES, 0);
		end
		if (!found) return ST_FAIL;
		// The last free block is never handed out.
		if (taken == list_head && list_len == 1) return ST_FAIL;
		unlink(taken);
		set_flag(taken, 0, 1'b0);
		set_flag(follower(taken), 32, 1'b0);
		pay = 16'(taken + HDR_BYTES);
		return ST_OK;
	endfunction

	function automatic status_t predict_free(int unsigned addr);
		int unsigned b, cur, aft, bef, far;
		bit          hit = 0;
		if (addr == 0) return ST_OK;
		if ((addr & 7) != 0 || addr < HDR_BYTES) return ST_FAIL;
		b = addr - HDR_BYTES;
		cur = 0;
		for (int unsigned k = 0; k < NWORDS && cur < ARENA - HDR_BYTES; k++) begin
			if (cur == b) begin
				hit = 1; break;
			end
			cur = follower(cur);
		end
		if (!hit) return ST_FAIL;
		if (flag(b, 0)) return ST_DOUBLE;
		set_flag(b, 0, 1'b1);
		aft = follower(b);
		set_flag(aft, 32, 1'b1);
		// Merge with a free left neighbor.
		if (flag(b, 32)) begin
			bef = b - (HDR_BYTES + fld(b, 32));
			set_fld(bef, 0, fld(bef, 0) + fld(b, 0) + HDR_BYTES);
			set_fld(aft, 32, fld(bef, 0));
			unlink(bef);
			b = bef;
		end
		// Merge with a free right neighbor.
		if (flag(aft, 0)) begin
			set_fld(b, 0, fld(b, 0) + fld(aft, 0) + HDR_BYTES);
			far = follower(aft);
			set_fld(far, 32, fld(b, 0));
			set_flag(far, 32, 1'b1);
			unlink(aft);
		end
		push_free(b);
		return ST_OK;
	endfunction

	function automatic int pick_gap();
		int r = $urandom_range(0, 99);
		if (quiet || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one request, wait for it to be taken and record its expected answer.
	task automatic send_req(logic o, logic [15:0] sz, logic [15:0] addr);
		alloc_result_t e;
		int            gap;
		int            idx;
		in_valid <= 1'b1;
		op <= o;
		request_size <= sz;
		address <= addr;
		forever begin
			@(negedge clk);
			if (in_ready) break;
			@(posedge clk);
		end
		if (o == OP_ALLOC) begin
			e.st = predict_alloc(sz, e.pay);
			if (e.st == ST_OK) live_blocks.push_back(e.pay);
		end else begin
			e.pay = '0;
			e.st = predict_free(addr);
			if (e.st == ST_OK && addr != 0) begin
				idx = -1;
				foreach (live_blocks[i]) if (live_blocks[i] == addr) idx = i;
				if (idx >= 0) live_blocks.delete(idx);
				released.push_back(addr);
				if (released.size() > 16) void'(released.pop_front());
			end
		end
		e.fb = list_len[11:0];
		pending_results.push_back(e);
		@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_size();
		int r = $urandom_range(0, 99);
		if (r < 70) return 16'($urandom_range(1, 256));
		if (r < 92) return 16'($urandom_range(1, 4096));
		if (r < 97) return 16'($urandom_range(0, 65535));
		return 16'd0;
	endfunction

	// One random request, biased toward well-formed allocate and free pairs.
	task automatic random_req();
		int r = $urandom_range(0, 99);
		int n = live_blocks.size();
		int want_alloc = (n < 8) ? 85 : (n > LIVE_CAP) ? 15 : 50;
		if (r < want_alloc) begin
			send_req(OP_ALLOC, pick_size(), 16'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 80 && n > 0)
				send_req(OP_FREE, 16'($urandom), live_blocks[$urandom_range(0, n - 1)]);
			else if (r < 88 && released.size() > 0)
				send_req(OP_FREE, 16'($urandom),
					released[$urandom_range(0, released.size() - 1)]);
			else if (r < 94)
				send_req(OP_FREE, 16'($urandom), 16'($urandom_range(1, 8191) * 8));
			else
				send_req(OP_FREE, 16'($urandom), 16'($urandom_range(0, 65535)));
		end
	endtask

	// Extremes of the fields and each corner of the allocator.
	task automatic test_directed();
		logic [15:0] big;
		send_req(OP_ALLOC, 16'd0, 16'hFFFF);
		send_req(OP_ALLOC, 16'hFFFF, 16'd0);
		send_req(OP_ALLOC, 16'd65520, 16'd0);
		send_req(OP_ALLOC, 16'd65496, 16'd0);
		big = live_blocks[$];
		send_req(OP_FREE, 16'd0, big);
		send_req(OP_FREE, 16'd0, big);
		send_req(OP_FREE, 16'hFFFF, 16'd0);
		send_req(OP_FREE, 16'd0, 16'd4);
		send_req(OP_FREE, 16'd0, 16'hFFFF);
		send_req(OP_FREE, 16'd0, 16'hFFF8);
		send_req(OP_ALLOC, 16'd1, 16'd0);
		send_req(OP_ALLOC, 16'd16, 16'd0);
		send_req(OP_ALLOC, 16'd17, 16'd0);
		send_req(OP_ALLOC, 16'd24, 16'd0);
		send_req(OP_FREE, 16'd0, live_blocks[1]);
		send_req(OP_ALLOC, 16'd16, 16'd0);
		send_req(OP_FREE, 16'd0, live_blocks[0]);
		send_req(OP_FREE, 16'd0, live_blocks[0]);
		send_req(OP_FREE, 16'd0, 16'd8);
		send_req(OP_FREE, 16'd0, live_blocks[0]);
		send_req(OP_FREE, 16'd0, live_blocks[0]);
		wait_drained();
	endtask

	task automatic test_random(int count, bit no_gaps);
		quiet = no_gaps;
		repeat (count) random_req();
		quiet = 1'b0;
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		hold_len = 600;
		repeat (20) random_req();
		wait_drained();
	endtask

	// Stimulus sequence.
	initial begin
		heap_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(600, 1'b0);
		test_backpressure();
		test_random(300, 1'b1);
		wait_drained();
		test_random(950, 1'b0);
		wait_drained();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: long hold-offs on request, low in reset, otherwise random stalls or, in quiet runs, always ready.
	always @(posedge clk) begin
		if (hold_len > 0 && !hold_started) begin
			hold_started <= 1'b1;
			hold_cycles  <= hold_len;
			out_ready    <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) < 75);
		end
	end

	// Compare each taken result against the oldest expectation.
	always @(negedge clk) begin
		alloc_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: pay=%0d st=%0d fb=%0d",
						payload_offset, status, free_blocks);
			end else begin
				e = pending_results.pop_front();
				if (payload_offset !== e.pay || status !== e.st || free_blocks !== e.fb) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp pay=%0d st=%0d fb=%0d, got pay=%0d st=%0d fb=%0d",
							e.pay, e.st, e.fb, payload_offset, status, free_blocks);
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
